// ===== rtl/xor_sprite_framebuffer_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef XOR_SPRITE_FRAMEBUFFER_UNIT_DEFINES_SVH
`define XOR_SPRITE_FRAMEBUFFER_UNIT_DEFINES_SVH

// property checked only outside reset
`define XSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define XSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/xsf_pkg.sv =====
// shared types and constants of the xor sprite framebuffer
`default_nettype none
package xsf_pkg;

  localparam int COLS      = 64;
  localparam int SPRITE_W  = 8;
  localparam int SUM_W     = 6;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [COLS-1:0] new_row;
    logic            hit;
    logic            pixel;
  } rmw_res_t;

endpackage
`default_nettype wire

// ===== rtl/xsf_ifs.sv =====
// command and result channel interfaces
`default_nettype none
interface xsf_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [5:0] column;
  logic [4:0] base_row;
  logic [3:0] row_offset;
  logic [7:0] sprite_bits;
  logic       first_row;
  logic       last_row;

  modport source (output valid, command, column, base_row, row_offset, sprite_bits,
                  first_row, last_row, input ready);
  modport sink (input valid, command, column, base_row, row_offset, sprite_bits,
                first_row, last_row, output ready);
endinterface

interface xsf_res_if;
  logic valid;
  logic ready;
  logic collided;
  logic pixel_value;

  modport source (output valid, collided, pixel_value, input ready);
  modport sink (input valid, collided, pixel_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/xsf_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module xsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/xsf_draw_unit.sv =====
// sprite placement, xor merge, collision and pixel pick for one frame row
`default_nettype none
module xsf_draw_unit (
  input  wire logic [xsf_pkg::COLS-1:0]     old_row,
  input  wire logic [5:0]                   column,
  input  wire logic [xsf_pkg::SPRITE_W-1:0] sprite_bits,
  output      xsf_pkg::rmw_res_t            res
);
  import xsf_pkg::*;

  logic [COLS-1:0]   pat;
  logic [2*COLS-1:0] dbl;
  logic [2*COLS-1:0] rot;

  // rotate right by the column so bit 7 of the sprite lands on that column
  assign dbl = {sprite_bits, {(COLS-SPRITE_W){1'b0}}, sprite_bits, {(COLS-SPRITE_W){1'b0}}};
  assign rot = dbl >> column;
  assign pat = rot[COLS-1:0];

  assign res.new_row = old_row ^ pat;
  assign res.hit     = |(old_row & pat);
  // column 0 is bit 63
  assign res.pixel   = old_row[~column];

endmodule
`default_nettype wire

// ===== rtl/xor_sprite_framebuffer_unit.sv =====
// top level: xor sprite framebuffer with row memory and read-modify-write control
//
//   channel  dir  words
//   cmd      in   clear / draw one sprite row / read one pixel
//   res      out  collided after a last draw row, pixel_value after a read
//
// clear and the unused command stay in idle: a clear drops the row valid bits at once.
// draw and read pass through the rmw state: one frame memory read, then modify and write back.
// a result that cannot leave holds the rmw state until the output register frees.
// reset blanks the frame through the valid bits; no clearing pass.
// a new command is taken while the previous result still waits at the output.
`default_nettype none
module xor_sprite_framebuffer_unit #(
  parameter int DISPLAY_ROWS    = 32,
  parameter int MAX_SPRITE_ROWS = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  xsf_cmd_if.sink   cmd,
  xsf_res_if.source res
);
  import xsf_pkg::*;

  localparam int ROW_W = $clog2(DISPLAY_ROWS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RMW  = 2'b10
  } state_t;

  state_t state, state_next;

  cmd_t              op;
  logic [5:0]        col_q;
  logic [ROW_W-1:0]  row_q;
  logic [7:0]        bits_q;
  logic              first_q;
  logic              last_q;
  logic              in_range_q;
  logic              flag;
  logic              flag_next;
  logic [DISPLAY_ROWS-1:0] row_valid;

  logic              accept;
  cmd_t              cmd_op;
  logic              in_range;
  logic [SUM_W-1:0]  draw_sum;
  logic [ROW_W-1:0]  rd_row;
  logic              rd_en;
  logic [COLS-1:0]   rd_data;
  logic [COLS-1:0]   old_row;
  rmw_res_t          calc;
  logic              need_res;
  logic              done;
  logic              wr_en;

  logic              out_valid;
  logic              out_collided;
  logic              out_pixel;

  function automatic logic [ROW_W-1:0] wrap_row(input logic [SUM_W-1:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, v};
    for (int i = 0; i < 3; i++) begin
      if (t >= (SUM_W+1)'(DISPLAY_ROWS)) begin
        t = t - (SUM_W+1)'(DISPLAY_ROWS);
      end
    end
    return t[ROW_W-1:0];
  endfunction

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign cmd_op    = cmd_t'(cmd.command);
  assign in_range  = {2'b00, cmd.row_offset} < SUM_W'(MAX_SPRITE_ROWS);
  assign draw_sum  = SUM_W'({1'b0, cmd.base_row}) + SUM_W'(cmd.row_offset);
  assign rd_row    = (cmd_op == CMD_DRAW) ? wrap_row(draw_sum)
                                          : wrap_row(SUM_W'(cmd.base_row));
  assign rd_en     = accept && ((cmd_op == CMD_DRAW) || (cmd_op == CMD_READ));

  xsf_ram #(
    .WIDTH (COLS),
    .DEPTH (DISPLAY_ROWS)
  ) u_frame (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (row_q),
    .wr_data (calc.new_row),
    .rd_en   (rd_en),
    .rd_addr (rd_row),
    .rd_data (rd_data)
  );

  // a row never written since the last clear reads as blank
  assign old_row = row_valid[row_q] ? rd_data : '0;

  xsf_draw_unit u_draw (
    .old_row     (old_row),
    .column      (col_q),
    .sprite_bits (bits_q),
    .res         (calc)
  );

  assign need_res  = (op == CMD_READ) || ((op == CMD_DRAW) && last_q);
  assign done      = (state == ST_RMW) && (!need_res || !out_valid || res.ready);
  assign wr_en     = done && (op == CMD_DRAW) && in_range_q;
  assign flag_next = (first_q ? 1'b0 : flag) | (in_range_q & calc.hit);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (rd_en) begin
          state_next = ST_RMW;
        end
      end
      ST_RMW: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      flag      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (cmd_op == CMD_CLEAR)) begin
        row_valid <= '0;
      end else if (wr_en) begin
        row_valid[row_q] <= 1'b1;
      end
      if (done && (op == CMD_DRAW)) begin
        flag <= flag_next;
      end
      if (done && need_res) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      op         <= cmd_op;
      col_q      <= cmd.column;
      row_q      <= rd_row;
      bits_q     <= cmd.sprite_bits;
      first_q    <= cmd.first_row;
      last_q     <= cmd.last_row;
      in_range_q <= in_range;
    end
    if (done && need_res) begin
      out_collided <= (op == CMD_DRAW) ? flag_next : 1'b0;
      out_pixel    <= (op == CMD_READ) ? calc.pixel : 1'b0;
    end
  end

  assign res.valid       = out_valid;
  assign res.collided    = out_collided;
  assign res.pixel_value = out_pixel;

endmodule
`default_nettype wire

// ===== rtl/xsf_checker.sv =====
// port-level checker for the xor sprite framebuffer, bound to the top level
`default_nettype none
`include "xor_sprite_framebuffer_unit_defines.svh"
module xsf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_command,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_collided,
  input wire logic       out_pixel
);
  import xsf_pkg::*;

  // a draw or read holds the memory for its read-modify-write, so the input is not ready
  `XSF_ASSERT(a_rmw_busy, in_valid && in_ready && (in_command == CMD_DRAW || in_command == CMD_READ) |=> !in_ready, "command taken during read-modify-write")
  // clear leaves the input ready
  `XSF_ASSERT(a_clear_quick, in_valid && in_ready && in_command == CMD_CLEAR |=> in_ready, "clear did not finish in one cycle")
  // a word carries either a collision or a pixel, never both set
  `XSF_ASSERT(a_one_kind, out_valid |-> !(out_collided && out_pixel), "collided and pixel_value both set")
  `XSF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_collided) && $stable(out_pixel), "stalled result word changed")
  `XSF_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result word present after reset")

endmodule

bind xor_sprite_framebuffer_unit xsf_checker u_xsf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (cmd.valid),
  .in_ready     (cmd.ready),
  .in_command   (cmd.command),
  .out_valid    (res.valid),
  .out_ready    (res.ready),
  .out_collided (res.collided),
  .out_pixel    (res.pixel_value)
);
`default_nettype wire

// ===== verif/tb.sv =====
// testbench for the xor sprite framebuffer: queued stimulus, model-based checking
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xsf_pkg::*;

  localparam int NUM_ROWS    = 32;
  localparam int SPRITE_ROWS = 16;
  localparam int RANDOM_WORDS = 450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] command;
    logic [5:0] column;
    logic [4:0] base_row;
    logic [3:0] row_offset;
    logic [7:0] sprite_bits;
    logic       first_row;
    logic       last_row;
  } cmd_word_t;

  typedef struct {
    logic collided;
    logic pixel_value;
  } res_word_t;

  logic clk;
  logic rst;

  xsf_cmd_if cmd_ch ();
  xsf_res_if res_ch ();

  xor_sprite_framebuffer_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // shadow copy of the frame and the sticky collision flag
  logic [63:0] frame_shadow [NUM_ROWS];
  logic        hit_flag;

  cmd_word_t pending_words[$];
  res_word_t expected_res[$];
  cmd_word_t on_bus;

  int total_words;
  int words_taken;
  int burst_left;
  int gap_left;
  int mismatches;
  int results_seen;
  int collided_ones;
  int pixel_ones;
  int cycle_cnt;
  int hold_cnt;
  bit hold_done;
  int window_cnt;
  int stall_mode;
  logic [7:0] stall_pattern;
  logic ready_bit;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_CLEAR;
    cmd_ch.column = '0;
    cmd_ch.base_row = '0;
    cmd_ch.row_offset = '0;
    cmd_ch.sprite_bits = '0;
    cmd_ch.first_row = 1'b0;
    cmd_ch.last_row = 1'b0;
    res_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // advance the frame model by one accepted word and queue its result
  function automatic void predict_word(cmd_word_t w);
    logic [63:0] placed;
    logic [4:0]  row;
    res_word_t   r;
    r.collided = 1'b0;
    r.pixel_value = 1'b0;
    if (w.command == CMD_CLEAR) begin
      for (int i = 0; i < NUM_ROWS; i++) frame_shadow[i] = '0;
    end else if (w.command == CMD_DRAW) begin
      if (w.first_row) hit_flag = 1'b0;
      if (int'(w.row_offset) < SPRITE_ROWS) begin
        row = 5'((int'(w.base_row) + int'(w.row_offset)) % NUM_ROWS);
        // rotate right so pixels past column 63 wrap to column 0
        placed = ({w.sprite_bits, 56'b0} >> w.column) |
                 ({w.sprite_bits, 56'b0} << (64 - int'(w.column)));
        if ((frame_shadow[row] & placed) != '0) hit_flag = 1'b1;
        frame_shadow[row] = frame_shadow[row] ^ placed;
      end
      if (w.last_row) begin
        r.collided = hit_flag;
        expected_res.push_back(r);
      end
    end else if (w.command == CMD_READ) begin
      row = 5'(int'(w.base_row) % NUM_ROWS);
      r.pixel_value = frame_shadow[row][63 - int'(w.column)];
      expected_res.push_back(r);
    end
  endfunction

  task automatic add_word(logic [1:0] c, int col, int row, int off, int bits,
                          int first, int last);
    cmd_word_t w;
    w.command = c;
    w.column = 6'(col);
    w.base_row = 5'(row);
    w.row_offset = 4'(off);
    w.sprite_bits = 8'(bits);
    w.first_row = 1'(first);
    w.last_row = 1'(last);
    pending_words.push_back(w);
  endtask

  task automatic add_sprite(int col, int row, int n);
    for (int i = 0; i < n; i++)
      add_word(CMD_DRAW, col, row, i, $urandom_range(0, 255), int'(i == 0),
               int'(i == n - 1));
  endtask

  // command driver: bursts of words with random gaps in between
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
      words_taken <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_word(on_bus);
        words_taken <= words_taken + 1;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          cmd_ch.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          on_bus = pending_words.pop_front();
          cmd_ch.command <= on_bus.command;
          cmd_ch.column <= on_bus.column;
          cmd_ch.base_row <= on_bus.base_row;
          cmd_ch.row_offset <= on_bus.row_offset;
          cmd_ch.sprite_bits <= on_bus.sprite_bits;
          cmd_ch.first_row <= on_bus.first_row;
          cmd_ch.last_row <= on_bus.last_row;
          cmd_ch.valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // one long hold-off on the result side once traffic is flowing
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_taken >= 120) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // result ready: stall mode and pattern are redrawn each time window_cnt wraps
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      window_cnt <= 0;
      stall_mode <= 0;
      stall_pattern <= 8'hff;
    end else begin
      window_cnt <= (window_cnt + 1) % 64;
      if (window_cnt == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_pattern <= 8'($urandom_range(1, 255));
      end else begin
        stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      end
      case (stall_mode)
        0: ready_bit = 1'b1;
        1: ready_bit = 1'($urandom_range(0, 1));
        2: ready_bit = stall_pattern[0];
        default: ready_bit = ($urandom_range(0, 3) == 0);
      endcase
      res_ch.ready <= ready_bit && (hold_cnt == 0);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result word: collided=%0b pixel_value=%0b",
                   $realtime, res_ch.collided, res_ch.pixel_value);
      end else begin
        res_word_t e;
        e = expected_res.pop_front();
        results_seen++;
        collided_ones += int'(res_ch.collided);
        pixel_ones += int'(res_ch.pixel_value);
        if (res_ch.collided !== e.collided || res_ch.pixel_value !== e.pixel_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: expected collided=%0b pixel_value=%0b, got %0b %0b",
                     $realtime, e.collided, e.pixel_value,
                     res_ch.collided, res_ch.pixel_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_res.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int pick, col, row, n;
    for (int i = 0; i < NUM_ROWS; i++) frame_shadow[i] = '0;
    hit_flag = 1'b0;
    mismatches = 0;
    results_seen = 0;
    collided_ones = 0;
    pixel_ones = 0;
    cycle_cnt = 0;

    // blank frame after reset, corner pixels
    add_word(CMD_READ, 0, 0, 0, 0, 0, 0);
    add_word(CMD_READ, 63, 31, 15, 255, 1, 1);
    // single-row sprite at column 0, then the same again to erase it
    add_word(CMD_DRAW, 0, 0, 0, 'hff, 1, 1);
    add_word(CMD_READ, 0, 0, 0, 0, 0, 0);
    add_word(CMD_READ, 7, 0, 0, 0, 0, 0);
    add_word(CMD_READ, 8, 0, 0, 0, 0, 0);
    add_word(CMD_DRAW, 0, 0, 0, 'hff, 1, 1);
    // column wrap on row 31, row wrap at offset 15
    add_word(CMD_DRAW, 60, 31, 0, 'ha5, 1, 0);
    add_word(CMD_DRAW, 60, 31, 15, 'h81, 0, 1);
    add_word(CMD_READ, 60, 31, 0, 0, 0, 0);
    add_word(CMD_READ, 1, 31, 0, 0, 0, 0);
    add_word(CMD_READ, 0, 31, 0, 0, 0, 0);
    add_word(CMD_READ, 60, 14, 0, 0, 0, 0);
    add_word(CMD_DRAW, 63, 5, 0, 'h00, 1, 1);
    add_word(CMD_UNUSED, 63, 31, 15, 255, 1, 1);
    // collision without last row, then clear must keep the flag
    add_word(CMD_DRAW, 60, 31, 0, 'hff, 1, 0);
    add_word(CMD_CLEAR, 17, 9, 3, 'h5a, 1, 1);
    add_word(CMD_READ, 60, 31, 0, 0, 0, 0);
    add_word(CMD_DRAW, 10, 3, 1, 'h01, 0, 1);
    add_word(CMD_DRAW, 63, 31, 15, 'h80, 1, 1);
    add_word(CMD_READ, 63, 14, 0, 0, 0, 0);
    add_word(CMD_READ, 17, 4, 0, 0, 0, 0);

    while (pending_words.size() < RANDOM_WORDS + 22) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        col = $urandom_range(0, 63);
        row = $urandom_range(0, 31);
        n = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 15);
        add_sprite(col, row, n);
        // probe pixels inside the sprite just drawn
        repeat ($urandom_range(0, 3))
          add_word(CMD_READ, (col + $urandom_range(0, 7)) % 64,
                   (row + $urandom_range(0, n - 1)) % 32, $urandom_range(0, 15),
                   $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1));
      end else if (pick < 80) begin
        add_word(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 31),
                 $urandom_range(0, 15), $urandom_range(0, 255),
                 $urandom_range(0, 1), $urandom_range(0, 1));
      end else if (pick < 84) begin
        add_word(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 31),
                 $urandom_range(0, 15), $urandom_range(0, 255),
                 $urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
        // noise: any command, stray first/last marks
        add_word(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 31),
                 $urandom_range(0, 15), $urandom_range(0, 255),
                 $urandom_range(0, 1), $urandom_range(0, 1));
      end
    end
    total_words = pending_words.size();

    @(negedge rst);
    while (words_taken != total_words) @(posedge clk);
    while (expected_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d command words sent, %0d result words checked", total_words, results_seen);
    $display("collisions reported: %0d, lit pixels read: %0d, mismatches: %0d",
             collided_ones, pixel_ones, mismatches);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/xsf_pkg.sv
rtl/xsf_ifs.sv
rtl/xsf_ram.sv
rtl/xsf_draw_unit.sv
rtl/xor_sprite_framebuffer_unit.sv
rtl/xsf_checker.sv
verif/tb.sv
